FILE: hdl/jvl_pkg.sv
// Package for the JSON value locator: character codes, register indexes and shared types.
// Used by jvl_scan and json_value_locator; depends on nothing.
package jvl_pkg;

  localparam int unsigned KEY_WORDS     = 4;
  localparam int unsigned KEY_BITS      = KEY_WORDS * 64;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned RES_OFF_BITS  = 16;

  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;

  localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_MODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_BYTES_A  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_BYTES_B  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_BYTES_C  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_BYTES_D  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_INDEX = 3'd6;

  localparam logic MODE_KEY   = 1'b0;
  localparam logic MODE_INDEX = 1'b1;

  typedef struct packed {
    logic                search_mode;
    logic [5:0]          key_length;
    logic [KEY_BITS-1:0] key;
    logic [15:0]         target_index;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [RES_OFF_BITS-1:0] offset;
  } res_t;

endpackage

FILE: hdl/json_value_locator.sv
// Top level of the JSON value locator: stream ports, configuration registers, input and
// result registers around the jvl_scan core. Depends on jvl_pkg and jvl_scan.
//
// Channel  Direction  Handshake           Payload
// in_      slave      in_tvalid/tready    tdata: text_byte; tuser: search_start
// out_     master     out_tvalid/tready   tdata: value_offset; tuser: found
// cfg_     write      cfg_we              cfg_index, cfg_wdata
//
// One byte per cycle while no result is stalled: a byte waits in the input register and its result, if any,
// is written to the result register as the byte leaves it; the scan core updates all state in that cycle.
// out_tvalid comes from the result register, so a result passes the input register and then the result register.
// Reset is synchronous and active low; it leaves the block idle until a start byte.
// A stalled result holds the input register, which then holds in_tready low.
module json_value_locator import jvl_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 32,
  parameter int unsigned DEPTH_BITS    = 8,
  parameter int unsigned OFFSET_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] text_byte
  input  logic                     in_tuser,   // [0] search_start
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,  // [15:0] value_offset
  output logic                     out_tuser,  // [0] found
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_vld_r, out_vld_nxt;
  logic       out_found_r;
  logic [15:0] out_off_r;
  logic       go;
  logic       in_xfer;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEARCH_MODE:  cfg_r.search_mode  <= cfg_wdata[0];
        REG_KEY_LENGTH:   cfg_r.key_length   <= cfg_wdata[5:0];
        REG_KEY_BYTES_A:  cfg_r.key[63:0]    <= cfg_wdata;
        REG_KEY_BYTES_B:  cfg_r.key[127:64]  <= cfg_wdata;
        REG_KEY_BYTES_C:  cfg_r.key[191:128] <= cfg_wdata;
        REG_KEY_BYTES_D:  cfg_r.key[255:192] <= cfg_wdata;
        REG_TARGET_INDEX: cfg_r.target_index <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign go        = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || go;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) in_vld_nxt = 1'b1;
    else if (go) in_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (go) out_vld_nxt = res.valid;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
    if (go && res.valid) begin
      out_found_r <= res.found;
      out_off_r   <= res.offset;
    end
  end

  jvl_scan #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .DEPTH_BITS    (DEPTH_BITS),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (go),
    .text_byte    (in_byte_r),
    .search_start (in_start_r),
    .cfg          (cfg_r),
    .res          (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_off_r;
  assign out_tuser  = out_found_r;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_vld_r)
    else $error("block not idle after reset");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0)
    else $error("not-found result with non-zero offset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_vld_r && out_vld_r && !out_tready)
    else $error("input stalled without a waiting result");

endmodule

FILE: hdl/jvl_scan.sv
// Scan core of the JSON value locator: nesting, string and key-match state, one byte per enable.
// Depends on jvl_pkg; the result it gives is combinational and is registered by the top level.
module jvl_scan import jvl_pkg::*; #(
  parameter int unsigned MAX_KEY_BYTES = 32,
  parameter int unsigned DEPTH_BITS    = 8,
  parameter int unsigned OFFSET_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] text_byte,
  input  logic       search_start,
  input  cfg_t       cfg,
  output res_t       res
);

  localparam logic [5:0] MaxKey = 6'(MAX_KEY_BYTES);

  logic [DEPTH_BITS-1:0]  curly_r, curly_nxt;
  logic [DEPTH_BITS-1:0]  square_r, square_nxt;
  logic                   str_r, str_nxt;
  logic [7:0]             prev_r, prev_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   mact_r, mact_nxt;
  logic [5:0]             mprog_r, mprog_nxt;
  logic                   colon_seen_r, colon_seen_nxt;
  logic [OFFSET_BITS-1:0] colon_off_r, colon_off_nxt;
  logic [15:0]            commas_r, commas_nxt;
  logic                   fin_r, fin_nxt;

  logic [5:0]                   klen;
  logic [OFFSET_BITS-1:0]       next_pos;
  logic [OFFSET_BITS-1:0]       hit_off;
  logic [OFFSET_BITS+15:0]      off_ext;
  logic                         hit;
  logic                         run;
  logic                         is_brk;
  logic [7:0]                   kbyte;

  function automatic logic [4:0] mprog_nxt_base(input logic [5:0] p, input logic s);
    mprog_nxt_base = s ? 5'd0 : p[4:0];
  endfunction

  assign klen  = (cfg.key_length > MaxKey) ? MaxKey : cfg.key_length;
  assign kbyte = cfg.key[{mprog_nxt_base(mprog_r, search_start), 3'b000} +: 8];

  always_comb begin
    curly_nxt      = curly_r;
    square_nxt     = square_r;
    str_nxt        = str_r;
    prev_nxt       = prev_r;
    pos_nxt        = pos_r;
    mact_nxt       = mact_r;
    mprog_nxt      = mprog_r;
    colon_seen_nxt = colon_seen_r;
    colon_off_nxt  = colon_off_r;
    commas_nxt     = commas_r;
    fin_nxt        = fin_r;
    hit            = 1'b0;
    hit_off        = '0;
    run            = 1'b0;
    next_pos       = '0;
    is_brk         = 1'b0;
    off_ext        = '0;
    res            = '0;

    if (search_start) begin
      curly_nxt      = '0;
      square_nxt     = '0;
      str_nxt        = 1'b0;
      prev_nxt       = 8'd0;
      pos_nxt        = '0;
      mact_nxt       = 1'b0;
      mprog_nxt      = 6'd0;
      colon_seen_nxt = 1'b0;
      colon_off_nxt  = '0;
      commas_nxt     = cfg.target_index;
      fin_nxt        = 1'b0;
      if (cfg.search_mode == MODE_INDEX && cfg.target_index == 16'd0) begin
        fin_nxt    = 1'b1;
        res.valid  = 1'b1;
        res.found  = 1'b1;
        res.offset = 16'd1;
      end else begin
        run = 1'b1;
      end
    end else begin
      run = !fin_r;
    end

    if (run) begin
      next_pos = pos_nxt + 1'b1;
      is_brk   = text_byte == CH_LCURLY || text_byte == CH_RCURLY ||
                 text_byte == CH_LSQUARE || text_byte == CH_RSQUARE;

      if (cfg.search_mode == MODE_KEY) begin
        if (mact_nxt) begin
          if (text_byte == CH_COLON && !colon_seen_nxt) begin
            colon_seen_nxt = 1'b1;
            colon_off_nxt  = next_pos;
          end
          if (mprog_nxt < klen) begin
            if (text_byte == kbyte) mprog_nxt = mprog_nxt + 6'd1;
            else mact_nxt = 1'b0;
          end else if (mprog_nxt == klen) begin
            if (text_byte == CH_QUOTE) mprog_nxt = mprog_nxt + 6'd1;
            else mact_nxt = 1'b0;
          end else begin
            mact_nxt = 1'b0;
            if (text_byte == CH_COLON) begin
              hit     = 1'b1;
              hit_off = colon_seen_nxt ? colon_off_nxt : next_pos;
            end
          end
        end
        if (!str_nxt) begin
          if (is_brk) begin
            case (text_byte)
              CH_LCURLY:  curly_nxt  = curly_nxt + 1'b1;
              CH_RCURLY:  curly_nxt  = curly_nxt - 1'b1;
              CH_LSQUARE: square_nxt = square_nxt + 1'b1;
              default:    square_nxt = square_nxt - 1'b1;
            endcase
          end else if (curly_nxt == DEPTH_BITS'(1) && text_byte == CH_QUOTE && !hit) begin
            mact_nxt       = 1'b1;
            mprog_nxt      = 6'd0;
            colon_seen_nxt = 1'b0;
            colon_off_nxt  = '0;
          end
        end
      end else begin
        if (!str_nxt) begin
          if (is_brk) begin
            case (text_byte)
              CH_LCURLY:  curly_nxt  = curly_nxt + 1'b1;
              CH_RCURLY:  curly_nxt  = curly_nxt - 1'b1;
              CH_LSQUARE: square_nxt = square_nxt + 1'b1;
              default:    square_nxt = square_nxt - 1'b1;
            endcase
          end else if (text_byte == CH_COMMA && curly_nxt == '0 &&
                       square_nxt == DEPTH_BITS'(1)) begin
            commas_nxt = commas_nxt - 16'd1;
            if (commas_nxt == 16'd0) begin
              hit     = 1'b1;
              hit_off = next_pos;
            end
          end
        end
      end

      if (text_byte == CH_QUOTE && prev_nxt != CH_BACKSLASH) str_nxt = !str_nxt;
      prev_nxt = text_byte;
      pos_nxt  = next_pos;

      off_ext = {16'd0, hit_off};
      if (hit) begin
        fin_nxt    = 1'b1;
        res.valid  = 1'b1;
        res.found  = 1'b1;
        res.offset = off_ext[RES_OFF_BITS-1:0];
      end else if ((cfg.search_mode == MODE_KEY ? curly_nxt : square_nxt) == '0) begin
        fin_nxt   = 1'b1;
        res.valid = 1'b1;
      end
    end

    if (!en) res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curly_r      <= '0;
      square_r     <= '0;
      str_r        <= 1'b0;
      prev_r       <= 8'd0;
      pos_r        <= '0;
      mact_r       <= 1'b0;
      mprog_r      <= 6'd0;
      colon_seen_r <= 1'b0;
      colon_off_r  <= '0;
      commas_r     <= 16'd0;
      fin_r        <= 1'b1;
    end else if (en) begin
      curly_r      <= curly_nxt;
      square_r     <= square_nxt;
      str_r        <= str_nxt;
      prev_r       <= prev_nxt;
      pos_r        <= pos_nxt;
      mact_r       <= mact_nxt;
      mprog_r      <= mprog_nxt;
      colon_seen_r <= colon_seen_nxt;
      colon_off_r  <= colon_off_nxt;
      commas_r     <= commas_nxt;
      fin_r        <= fin_nxt;
    end
  end

  // A partial key match never runs past the key length and its closing quote.
  a_mprog_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mact_r |-> mprog_r <= MaxKey + 6'd1)
    else $error("key match progress out of range");

  // Any result finishes the search, so the next byte without a start flag is ignored.
  a_res_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> fin_r)
    else $error("search still running after a result");

  // With no search running, a byte without a start flag gives no result.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r && !search_start |-> !res.valid)
    else $error("result while no search is running");

endmodule
